// File: rtl/imu_packet_parse_calibrate_core_defines.svh
// assertion helpers used by the sequencer rtl
`ifndef IMU_PACKET_PARSE_CALIBRATE_CORE_DEFINES_SVH
`define IMU_PACKET_PARSE_CALIBRATE_CORE_DEFINES_SVH

// property must hold at every clock edge out of reset
`define IPC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// expression must never be true out of reset
`define IPC_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// File: rtl/ipc_pkg.sv
package ipc_pkg;

   // widths
   localparam int IDX_W = 6;
   localparam int STEP_W = 5;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 48;

   // header bytes
   localparam logic [7:0] HDR_BYTE0 = 8'h55;
   localparam logic [7:0] HDR_BYTE1 = 8'hAA;

   // byte positions
   localparam int FRESH_BYTE = 20;
   localparam int KEPT_BYTES = 21;

   // status codes
   localparam logic [1:0] STAT_OK = 2'd0;
   localparam logic [1:0] STAT_HDR_ERR = 2'd1;
   localparam logic [1:0] STAT_SUM_ERR = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_GAIN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GYRO_GAIN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAG_GAIN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAG_OFFSET = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAG_ROW_A = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MAG_ROW_B = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_MAG_ROW_C = 3'd6;

   // register reset values
   localparam logic [31:0] MAG_GAIN_RST = 32'd10066330;
   localparam logic [47:0] MAG_OFFSET_RST = 48'd7687951743881;
   localparam logic [47:0] MAG_ROW_A_RST = 48'd850387549920;
   localparam logic [47:0] MAG_ROW_B_RST = 48'd1542950420236;
   localparam logic [47:0] MAG_ROW_C_RST = 48'd66464642433221;

   // multiply sequence: 0..5 accel/gyro, 6..8 mag scale, 9..17 matrix
   localparam logic [STEP_W-1:0] STEP_MAG0 = 5'd6;
   localparam logic [STEP_W-1:0] STEP_ROW0 = 5'd9;
   localparam logic [STEP_W-1:0] STEP_LAST = 5'd17;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_ACC,
      ST_OUT
   } ctrl_state_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       packet_start;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] accel_x;
      logic signed [31:0] accel_y;
      logic signed [31:0] accel_z;
      logic signed [31:0] rate_x;
      logic signed [31:0] rate_y;
      logic signed [31:0] rate_z;
      logic signed [31:0] field_x;
      logic signed [31:0] field_y;
      logic signed [31:0] field_z;
      logic               mag_fresh;
   } rsp_payload_type;

   typedef struct packed {
      logic              take;
      logic              first;
      logic              last;
      logic [IDX_W-1:0]  idx;
      logic              mul_en;
      logic              acc_en;
      logic [STEP_W-1:0] step;
   } ctrl_cmd_type;

   typedef struct packed {
      logic bad;
   } dp_status_type;

   // saturate to signed 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// File: rtl/ipc_chan_if.sv
interface ipc_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/ipc_ctrl.sv
`include "imu_packet_parse_calibrate_core_defines.svh"

module ipc_ctrl
   import ipc_pkg::*;
#(
   parameter int PACKET_BYTES = 22
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic          in_first,
   output logic          in_ready,
   output logic          out_valid,
   input  logic          out_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PACKET_BYTES - 1);

   ctrl_state_type    state_ff, state_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [IDX_W-1:0]  idx_base;
   logic              take;

   // state, byte count and step registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff <= '0;
         step_ff <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         step_ff <= step_in;
      end
   end

   // byte position of the current transfer
   assign take = in_valid && in_ready;
   assign idx_base = (in_first || idx_ff > LAST_IDX) ? '0 : idx_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      step_in = step_ff;
      in_ready = 1'b0;
      out_valid = 1'b0;
      cmd = '0;
      cmd.step = step_ff;
      cmd.idx = idx_base;
      cmd.first = in_first;
      cmd.last = (idx_base == LAST_IDX);
      case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            cmd.take = take;
            if (take) begin
               if (cmd.last) begin
                  idx_in = '0;
                  step_in = '0;
                  state_in = status.bad ? ST_OUT : ST_MUL;
               end else begin
                  idx_in = idx_base + 1'b1;
               end
            end
         end
         ST_MUL: begin
            cmd.mul_en = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc_en = 1'b1;
            if (step_ff == STEP_LAST) begin
               step_in = '0;
               state_in = ST_OUT;
            end else begin
               step_in = step_ff + 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_OUT: begin
            out_valid = 1'b1;
            if (out_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `IPC_NEVER(a_no_overlap, clock, reset, in_ready && out_valid, "input taken while result pending")
   `IPC_NEVER(a_step_range, clock, reset, step_ff > STEP_LAST, "multiply step out of range")
   `IPC_ASSERT(a_last_starts, clock, reset, (take && cmd.last && !status.bad) |=> (state_ff == ST_MUL), "good packet did not start compute")
   `IPC_ASSERT(a_bad_direct, clock, reset, (take && cmd.last && status.bad) |=> out_valid, "bad packet result not shown")

endmodule

// File: rtl/ipc_datapath.sv
module ipc_datapath
   import ipc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [7:0]            rx_byte,
   input  ctrl_cmd_type          cmd,
   output dp_status_type         status,
   output rsp_payload_type       result
);

   logic [31:0] accel_gain_ff, gyro_gain_ff, mag_gain_ff;
   logic [47:0] mag_offset_ff, row_a_ff, row_b_ff, row_c_ff;
   logic [7:0]  sum_ff;
   logic [7:0]  pkt_ff [KEPT_BYTES];
   logic [1:0]  status_ff, status_in;
   logic        fresh_ff;
   logic signed [31:0] res_ff [9];
   logic signed [41:0] m_ff [3];
   logic signed [57:0] prod_ff;
   logic signed [59:0] acc_ff;

   logic signed [15:0] op_a;
   logic signed [41:0] op_b;
   logic signed [15:0] word;
   logic [31:0]        gain;
   logic [1:0]         row, col;
   logic [47:0]        row_reg;
   logic signed [63:0] rnd8, rnd14, row_tot;
   logic signed [59:0] acc_sum;
   logic signed [41:0] off_ext;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         accel_gain_ff <= '0;
         gyro_gain_ff <= '0;
         mag_gain_ff <= MAG_GAIN_RST;
         mag_offset_ff <= MAG_OFFSET_RST;
         row_a_ff <= MAG_ROW_A_RST;
         row_b_ff <= MAG_ROW_B_RST;
         row_c_ff <= MAG_ROW_C_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ACCEL_GAIN: accel_gain_ff <= csr_wdata[31:0];
            CSR_GYRO_GAIN:  gyro_gain_ff <= csr_wdata[31:0];
            CSR_MAG_GAIN:   mag_gain_ff <= csr_wdata[31:0];
            CSR_MAG_OFFSET: mag_offset_ff <= csr_wdata;
            CSR_MAG_ROW_A:  row_a_ff <= csr_wdata;
            CSR_MAG_ROW_B:  row_b_ff <= csr_wdata;
            CSR_MAG_ROW_C:  row_c_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // header and checksum check on the final byte
   always_comb begin
      if (pkt_ff[0] != HDR_BYTE0 || pkt_ff[1] != HDR_BYTE1) begin
         status_in = STAT_HDR_ERR;
      end else if (sum_ff != rx_byte) begin
         status_in = STAT_SUM_ERR;
      end else begin
         status_in = STAT_OK;
      end
   end
   assign status.bad = (status_in != STAT_OK);

   // byte capture and running sum
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else if (cmd.take) begin
         sum_ff <= cmd.last ? 8'd0 : ((cmd.first ? 8'd0 : sum_ff) + rx_byte);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take && cmd.idx < IDX_W'(KEPT_BYTES)) begin
         pkt_ff[cmd.idx[4:0]] <= rx_byte;
      end
   end

   // operand selection per step
   always_comb begin
      word = '0;
      gain = mag_gain_ff;
      row = 2'd0;
      col = 2'd0;
      case (cmd.step)
         5'd0: begin word = {pkt_ff[2], pkt_ff[3]}; gain = accel_gain_ff; end
         5'd1: begin word = {pkt_ff[4], pkt_ff[5]}; gain = accel_gain_ff; end
         5'd2: begin word = {pkt_ff[6], pkt_ff[7]}; gain = accel_gain_ff; end
         5'd3: begin word = {pkt_ff[8], pkt_ff[9]}; gain = gyro_gain_ff; end
         5'd4: begin word = {pkt_ff[10], pkt_ff[11]}; gain = gyro_gain_ff; end
         5'd5: begin word = {pkt_ff[12], pkt_ff[13]}; gain = gyro_gain_ff; end
         5'd6: word = {pkt_ff[15], pkt_ff[14]};
         5'd7: word = {pkt_ff[17], pkt_ff[16]};
         5'd8: word = {pkt_ff[19], pkt_ff[18]};
         5'd9:  begin row = 2'd0; col = 2'd0; end
         5'd10: begin row = 2'd0; col = 2'd1; end
         5'd11: begin row = 2'd0; col = 2'd2; end
         5'd12: begin row = 2'd1; col = 2'd0; end
         5'd13: begin row = 2'd1; col = 2'd1; end
         5'd14: begin row = 2'd1; col = 2'd2; end
         5'd15: begin row = 2'd2; col = 2'd0; end
         5'd16: begin row = 2'd2; col = 2'd1; end
         5'd17: begin row = 2'd2; col = 2'd2; end
         default: ;
      endcase
   end

   // row b gives x, row a gives y, row c gives negated z
   always_comb begin
      case (row)
         2'd0:    row_reg = row_b_ff;
         2'd1:    row_reg = row_a_ff;
         default: row_reg = row_c_ff;
      endcase
   end

   always_comb begin
      if (cmd.step < STEP_ROW0) begin
         op_a = word;
         op_b = $signed({10'd0, gain});
      end else begin
         op_a = $signed(row_reg[16*col +: 16]);
         op_b = m_ff[col];
      end
   end

   // shared multiplier
   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= op_a * op_b;
      end
   end

   // rounding, offset and accumulation
   always_comb begin
      rnd8 = (64'(prod_ff) + 64'sd128) >>> 8;
      off_ext = 42'($signed(mag_offset_ff[16*(cmd.step - STEP_MAG0) +: 16])) <<< 12;
      acc_sum = (col == 2'd0 ? 60'sd0 : acc_ff) + 60'(prod_ff);
      row_tot = (row == 2'd2) ? -64'(acc_sum) : 64'(acc_sum);
      rnd14 = (row_tot + 64'sd8192) >>> 14;
   end

   always_ff @(posedge clock) begin
      if (cmd.take && cmd.last) begin
         for (int k = 0; k < 9; k++) begin
            res_ff[k] <= '0;
         end
         status_ff <= status_in;
         fresh_ff <= (status_in == STAT_OK) && (pkt_ff[FRESH_BYTE] != 8'd0);
      end else if (cmd.acc_en) begin
         if (cmd.step < STEP_MAG0) begin
            res_ff[cmd.step[2:0]] <= sat32(rnd8);
         end else if (cmd.step < STEP_ROW0) begin
            m_ff[2'(cmd.step - STEP_MAG0)] <= rnd8[41:0] + off_ext;
         end else begin
            acc_ff <= acc_sum;
            if (col == 2'd2) begin
               res_ff[4'd6 + 4'(row)] <= sat32(rnd14);
            end
         end
      end
   end

   // result word
   always_comb begin
      result.status = status_ff;
      result.accel_x = res_ff[0];
      result.accel_y = res_ff[1];
      result.accel_z = res_ff[2];
      result.rate_x = res_ff[3];
      result.rate_y = res_ff[4];
      result.rate_z = res_ff[5];
      result.field_x = res_ff[6];
      result.field_y = res_ff[7];
      result.field_z = res_ff[8];
      result.mag_fresh = fresh_ff;
   end

endmodule

// File: rtl/imu_packet_parse_calibrate_core.sv
// channel   dir  transfer unit
// req_chan  in   one packet byte with its start flag
// rsp_chan  out  one calibrated sample per complete packet
// csr_*     in   register write, no read-back
//
// bytes are taken while idle; the final byte of a good packet runs 18 steps
// of the shared 16x42 multiplier, each a multiply then an accumulate state,
// before the result; a bad header or checksum shows its result in the cycle
// after the final byte; no byte is taken while a result waits; synchronous
// reset clears the byte count, sum and sequencer and resets the csrs

module imu_packet_parse_calibrate_core
   import ipc_pkg::*;
#(
   parameter int PACKET_BYTES = 22
) (
   input  logic                  clock,
   input  logic                  reset,
   ipc_chan_if.sink              req_chan,
   ipc_chan_if.source            rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // sequencer
   ipc_ctrl #(.PACKET_BYTES(PACKET_BYTES)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_first  (req_chan.payload.packet_start),
      .in_ready  (req_chan.ready),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic and storage
   ipc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rx_byte   (req_chan.payload.rx_byte),
      .cmd       (cmd),
      .status    (status),
      .result    (rsp_chan.payload)
   );

endmodule
